/* hw/rtl/cps_pkg.sv */
// shared types and codes for the current profile sequencer
`timescale 1ns / 1ps

package cps_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_RAMP   = 2'd1;
    localparam logic [1:0] OP_REPEAT = 2'd2;

    localparam int DAC_W = 12;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         wr_index;
        logic [1:0]         wr_op;
        logic signed [31:0] wr_arg_level;
        logic [31:0]        wr_arg_ticks;
    } t_in;

    typedef struct packed {
        logic [DAC_W-1:0]   dac_code;
        logic signed [31:0] level_ma;
        logic               running;
        logic               dac_written;
    } t_out;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] arg;
        logic [31:0] ticks;
    } t_entry;

endpackage

/* hw/rtl/cps_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/current_profile_sequencer_core.sv */
// top level of the current profile sequencer
`timescale 1ns / 1ps

// Runs a load-current profile from a step table held in one RAM. Each input
// beat has an accept cycle, which for a tick reads the next table entry (a
// write beat stores its entry there), and an update cycle, which updates the
// sequencer state and waits while an earlier result is still pending; the
// result then goes to an output register that can hold one beat while the
// next input is accepted. No beat is accepted during an update cycle, due to
// the registered table read. Entry 0 is also held in a register so start and
// repeat enter it without a second read. The DAC code is derived from the
// level by a constant-reciprocal multiply in the output stage. No clearing pass.
module current_profile_sequencer_core
    import cps_pkg::*;
#(
    parameter int MAX_STEPS = 16,
    parameter int VREF_MV   = 1200
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data
);

    localparam int AW = $clog2(MAX_STEPS);
    localparam int PW = $clog2(MAX_STEPS + 1);
    localparam int CW = (PW > 5) ? PW : 5;
    localparam int XW = (AW > 4) ? AW : 4;
    localparam int unsigned DIV = VREF_MV * 20;
    localparam int unsigned SAT = (DIV + 7) / 8;
    localparam int MW = $clog2(SAT + 1);
    localparam int RS = 31;
    localparam logic [32:0] RECIP =
        33'(((64'd1 << (RS + 15)) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic               r_busy;
    t_in                r_item;
    logic               r_pend;
    logic               r_pend_run;
    logic               r_pend_wr;
    logic               r_out_valid;
    t_out               r_out;

    logic [PW-1:0]      r_pos,   n_pos;
    logic [31:0]        r_ticks, n_ticks;
    logic [31:0]        r_reps,  n_reps;
    logic signed [31:0] r_level, n_level;
    logic               r_active, n_active;
    logic [4:0]         r_step_count;
    logic [1:0]         r_cur_op, n_cur_op;
    logic signed [31:0] r_cur_delta, n_cur_delta;
    t_entry             r_e0;
    logic               n_wrote;

    logic               w_accept;
    logic               w_drain;
    logic               w_done;
    logic [XW-1:0]      w_idx;
    logic               w_idx_ok;
    logic               w_we;
    t_entry             w_wdata;
    t_entry             w_rdata;
    logic [PW-1:0]      w_pos_inc;
    logic               w_over;
    logic [31:0]        w_tick_dec;
    logic [31:0]        w_reps_inc;

    logic [MW-1:0]      w_ma;
    logic [MW+32:0]     w_prod;
    logic [MW+32:0]     w_quot;
    logic [DAC_W-1:0]   w_code;

    assign w_accept   = i_in_valid && !r_busy;
    assign w_drain    = r_pend && (!r_out_valid || !i_out_stall);
    assign w_done     = r_busy && (!r_pend || w_drain);
    assign o_in_stall = r_busy;

    assign w_idx    = XW'(i_in_data.wr_index);
    assign w_idx_ok = 32'(i_in_data.wr_index) < 32'(MAX_STEPS);
    assign w_we     = w_accept && (i_in_data.cmd == CMD_WRITE) && w_idx_ok;
    assign w_wdata  = '{op: i_in_data.wr_op, arg: i_in_data.wr_arg_level,
                        ticks: i_in_data.wr_arg_ticks};

    assign w_pos_inc  = r_pos + PW'(1);
    assign w_over     = (CW'(w_pos_inc) >= CW'(r_step_count))
                        || (w_pos_inc >= PW'(MAX_STEPS));
    assign w_tick_dec = r_ticks - 32'd1;
    assign w_reps_inc = r_reps + 32'd1;

    cps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_accept && (i_in_data.cmd == CMD_TICK)),
        .i_raddr (w_pos_inc[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_pos       = r_pos;
        n_ticks     = r_ticks;
        n_reps      = r_reps;
        n_level     = r_level;
        n_active    = r_active;
        n_cur_op    = r_cur_op;
        n_cur_delta = r_cur_delta;
        n_wrote     = 1'b0;
        unique case (r_item.cmd)
            CMD_TICK: begin
                if (r_active) begin
                    n_ticks = w_tick_dec;
                    if (w_tick_dec != 32'd0) begin
                        if (r_cur_op == OP_RAMP) begin
                            n_level = r_level + r_cur_delta;
                            n_wrote = 1'b1;
                        end
                    end else begin
                        n_pos = w_pos_inc;
                        if (w_over) begin
                            n_active = 1'b0;
                        end else begin
                            n_cur_op    = w_rdata.op;
                            n_cur_delta = w_rdata.arg;
                            case (w_rdata.op)
                                OP_HOLD: begin
                                    n_level = w_rdata.arg;
                                    n_ticks = w_rdata.ticks;
                                    n_wrote = 1'b1;
                                end
                                OP_RAMP: begin
                                    n_level = r_level + w_rdata.arg;
                                    n_ticks = w_rdata.ticks;
                                    n_wrote = 1'b1;
                                end
                                OP_REPEAT: begin
                                    n_reps = w_reps_inc;
                                    if (w_reps_inc == w_rdata.arg) begin
                                        n_active = 1'b0;
                                    end else begin
                                        if (w_rdata.arg == '1) begin
                                            n_reps = 32'd0;
                                        end
                                        n_pos       = '0;
                                        n_level     = r_e0.arg;
                                        n_ticks     = r_e0.ticks;
                                        n_cur_op    = r_e0.op;
                                        n_cur_delta = r_e0.arg;
                                        n_wrote     = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_WRITE: begin
                n_active = 1'b0;
            end
            CMD_START: begin
                n_pos       = '0;
                n_reps      = 32'd0;
                n_level     = r_e0.arg;
                n_ticks     = r_e0.ticks;
                n_cur_op    = r_e0.op;
                n_cur_delta = r_e0.arg;
                n_active    = 1'b1;
                n_wrote     = 1'b1;
            end
            CMD_STOP: begin
                n_active = 1'b0;
            end
        endcase
    end

    // level to dac code, exact reciprocal below the clamp point
    assign w_ma   = r_level[MW-1:0];
    assign w_prod = (MW + 33)'(w_ma) * (MW + 33)'(RECIP);
    assign w_quot = w_prod >> RS;

    always_comb begin
        if (r_level[31]) begin
            w_code = '0;
        end else if (r_level[30:0] >= 31'(SAT)) begin
            w_code = '1;
        end else begin
            w_code = w_quot[DAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_ticks      <= '0;
            r_reps       <= '0;
            r_level      <= '0;
            r_active     <= 1'b0;
            r_step_count <= 5'd1;
        end else begin
            if (i_cfg_we) begin
                r_step_count <= i_cfg_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_pend   <= 1'b1;
                r_pos    <= n_pos;
                r_ticks  <= n_ticks;
                r_reps   <= n_reps;
                r_level  <= n_level;
                r_active <= n_active;
            end else if (w_drain) begin
                r_pend <= 1'b0;
            end
            if (w_drain) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_we && (w_idx == '0)) begin
            r_e0 <= w_wdata;
        end
        if (w_done) begin
            r_cur_op    <= n_cur_op;
            r_cur_delta <= n_cur_delta;
            r_pend_run  <= n_active;
            r_pend_wr   <= n_wrote;
        end
        if (w_drain) begin
            r_out <= '{dac_code: w_code, level_ma: r_level,
                       running: r_pend_run, dac_written: r_pend_wr};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted beat did not enter the update cycle");

    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_pend) |=> !r_busy)
        else $error("update cycle held without a pending result");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos < PW'(MAX_STEPS)))
        else $error("running sequence beyond the step table");

    a_drain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drain |=> o_out_valid)
        else $error("pending result not presented");
`endif

endmodule

/* bench/tb_current_profile_sequencer_core.sv */
// self-checking testbench for the current profile sequencer core
`timescale 1ns / 1ps

module tb_current_profile_sequencer_core
    import cps_pkg::*;
();

    localparam int MAX_STEPS = 16;
    localparam int VREF_MV = 1200;
    localparam longint DAC_FULL_SCALE = 32768;
    localparam longint DAC_DIVIDER = 20;
    localparam longint DAC_TOP = 4095;
    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFF;
    localparam int RANDOM_BEATS = 680;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [4:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    t_in i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    // sequencer state as the bench sees it
    logic [1:0] tbl_op [MAX_STEPS];
    logic [31:0] tbl_arg [MAX_STEPS];
    logic [31:0] tbl_ticks [MAX_STEPS];
    int cur_step;
    logic [31:0] ticks_remaining;
    logic [31:0] loops_done;
    logic [31:0] cur_level;
    bit seq_active;
    logic [4:0] num_steps;

    t_out profile_outputs_q[$];
    int beats_sent;
    int live_beats;
    int results_checked;
    int mismatch_count;
    int table_settings;
    int idle_cycles;
    int holdoff_request;
    int holdoff_left;
    bit tx_gaps;
    bit rx_gaps;

    current_profile_sequencer_core #(
        .MAX_STEPS(MAX_STEPS),
        .VREF_MV(VREF_MV)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [11:0] ma_to_dac_code(input logic [31:0] ma);
        longint scaled;
        if (ma[31]) return '0;
        scaled = (longint'(ma) * DAC_FULL_SCALE) / (VREF_MV * DAC_DIVIDER);
        if (scaled > DAC_TOP) scaled = DAC_TOP;
        return scaled[11:0];
    endfunction

    function automatic void enter_first_step();
        cur_level = tbl_arg[0];
        ticks_remaining = tbl_ticks[0];
    endfunction

    function automatic bit tick_profile();
        ticks_remaining = ticks_remaining - 32'd1;
        if (ticks_remaining != 0) begin
            if (cur_step < MAX_STEPS && tbl_op[cur_step] == OP_RAMP) begin
                cur_level = cur_level + tbl_arg[cur_step];
                return 1'b1;
            end
            return 1'b0;
        end
        cur_step = cur_step + 1;
        if (cur_step >= num_steps || cur_step >= MAX_STEPS) begin
            seq_active = 1'b0;
            return 1'b0;
        end
        case (tbl_op[cur_step])
            OP_HOLD: begin
                cur_level = tbl_arg[cur_step];
                ticks_remaining = tbl_ticks[cur_step];
                return 1'b1;
            end
            OP_RAMP: begin
                cur_level = cur_level + tbl_arg[cur_step];
                ticks_remaining = tbl_ticks[cur_step];
                return 1'b1;
            end
            OP_REPEAT: begin
                loops_done = loops_done + 32'd1;
                if (loops_done == tbl_arg[cur_step]) begin
                    seq_active = 1'b0;
                    return 1'b0;
                end
                if (tbl_arg[cur_step] == REPEAT_FOREVER) loops_done = '0;
                cur_step = 0;
                enter_first_step();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_out profile_step(input t_in beat);
        t_out res;
        bit changed;
        changed = 1'b0;
        case (beat.cmd)
            CMD_TICK: begin
                if (seq_active) changed = tick_profile();
            end
            CMD_WRITE: begin
                seq_active = 1'b0;
                tbl_op[beat.wr_index] = beat.wr_op;
                tbl_arg[beat.wr_index] = beat.wr_arg_level;
                tbl_ticks[beat.wr_index] = beat.wr_arg_ticks;
            end
            CMD_START: begin
                cur_step = 0;
                loops_done = '0;
                enter_first_step();
                seq_active = 1'b1;
                changed = 1'b1;
            end
            default: seq_active = 1'b0;
        endcase
        res.dac_code = ma_to_dac_code(cur_level);
        res.level_ma = cur_level;
        res.running = seq_active;
        res.dac_written = changed;
        return res;
    endfunction

    function automatic t_in make_beat(input logic [1:0] cmd, input logic [3:0] idx,
                                      input logic [1:0] op, input logic [31:0] arg,
                                      input logic [31:0] dur);
        t_in beat;
        beat.cmd = cmd;
        beat.wr_index = idx;
        beat.wr_op = op;
        beat.wr_arg_level = arg;
        beat.wr_arg_ticks = dur;
        return beat;
    endfunction

    function automatic t_in random_beat(input logic [1:0] cmd);
        return make_beat(cmd, 4'($urandom_range(15)), 2'($urandom_range(3)),
                         $urandom, $urandom);
    endfunction

    function automatic t_in random_entry(input int idx);
        int pick;
        logic [1:0] op;
        logic [31:0] arg;
        logic [31:0] dur;
        pick = $urandom_range(99);
        if (pick < 45) op = OP_HOLD;
        else if (pick < 80) op = OP_RAMP;
        else if (pick < 95) op = OP_REPEAT;
        else op = OP_UNDEF;
        pick = $urandom_range(9);
        case (op)
            OP_HOLD: arg = (pick == 0) ? $urandom : $urandom_range(3500);
            OP_RAMP: arg = (pick == 0) ? $urandom : $urandom_range(400) - 200;
            OP_REPEAT: begin
                if (pick < 6) arg = $urandom_range(1, 3);
                else if (pick == 6) arg = REPEAT_FOREVER;
                else if (pick == 7) arg = '0;
                else arg = $urandom;
            end
            default: arg = $urandom;
        endcase
        pick = $urandom_range(19);
        if (pick == 0) dur = '0;
        else if (pick == 1) dur = $urandom;
        else dur = $urandom_range(1, 4);
        return make_beat(CMD_WRITE, 4'(idx), op, arg, dur);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch after %0d results: %s is %0h, expected %0h",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_output(input t_out got);
        t_out want;
        if (profile_outputs_q.size() == 0) begin
            report_mismatch("unexpected beat, level_ma", 64'(got.level_ma), '0);
            return;
        end
        want = profile_outputs_q.pop_front();
        results_checked++;
        if (got.dac_code !== want.dac_code)
            report_mismatch("dac_code", 64'(got.dac_code), 64'(want.dac_code));
        if (got.level_ma !== want.level_ma)
            report_mismatch("level_ma", 64'(got.level_ma), 64'(want.level_ma));
        if (got.running !== want.running)
            report_mismatch("running", 64'(got.running), 64'(want.running));
        if (got.dac_written !== want.dac_written)
            report_mismatch("dac_written", 64'(got.dac_written), 64'(want.dac_written));
    endtask

    // output side: check each beat, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            check_output(o_out_data);
        if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_gaps && ($urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("current_profile_sequencer_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input t_in beat);
        while (tx_gaps && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (beat.cmd != CMD_TICK || seq_active) live_beats++;
        beats_sent++;
        profile_outputs_q.push_back(profile_step(beat));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (profile_outputs_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_step_count(input logic [4:0] count);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        num_steps = count;
        table_settings++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_idle_commands();
        send_beat(random_beat(CMD_TICK));
        send_beat(random_beat(CMD_STOP));
    endtask

    // reset step count of one: a single hold then the end of the table
    task automatic test_single_hold();
        send_beat(make_beat(CMD_WRITE, 4'd0, OP_HOLD, 32'd2999, 32'd2));
        send_beat(random_beat(CMD_START));
        repeat (3) send_beat(random_beat(CMD_TICK));
    endtask

    task automatic test_ramp_wrap_and_unknown_op();
        load_step_count(5'd3);
        send_beat(make_beat(CMD_WRITE, 4'd0, OP_HOLD, 32'h7FFF_FFF0, 32'd1));
        send_beat(make_beat(CMD_WRITE, 4'd1, OP_RAMP, 32'd8, 32'd2));
        send_beat(make_beat(CMD_WRITE, 4'd2, OP_UNDEF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_beat(random_beat(CMD_START));
        repeat (4) send_beat(random_beat(CMD_TICK));
        send_beat(random_beat(CMD_STOP));
    endtask

    task automatic test_repeat_count();
        send_beat(make_beat(CMD_WRITE, 4'd2, OP_REPEAT, 32'd2, 32'hFFFF_FFFF));
        send_beat(random_beat(CMD_START));
        repeat (6) send_beat(random_beat(CMD_TICK));
    endtask

    // endless repeat, then a write mid-run and a ramp step with zero duration
    task automatic test_forever_and_zero_duration();
        send_beat(make_beat(CMD_WRITE, 4'd0, OP_HOLD, 32'h8000_0000, 32'd1));
        send_beat(make_beat(CMD_WRITE, 4'd2, OP_REPEAT, REPEAT_FOREVER, 32'd0));
        send_beat(random_beat(CMD_START));
        repeat (4) send_beat(random_beat(CMD_TICK));
        send_beat(make_beat(CMD_WRITE, 4'd1, OP_RAMP, 32'hFFFF_FFFD, 32'd0));
        send_beat(random_beat(CMD_START));
        repeat (3) send_beat(random_beat(CMD_TICK));
    endtask

    task automatic test_output_holdoff();
        wait_idle();
        tx_gaps = 1'b0;
        holdoff_request = HOLDOFF_CYCLES;
        send_beat(random_beat(CMD_START));
        repeat (20) send_beat(random_beat(CMD_TICK));
        wait_idle();
        tx_gaps = 1'b1;
    endtask

    task automatic run_random_phase(input int phase);
        int n_steps;
        int run_len;
        int pick;
        int i;
        case (phase)
            0: n_steps = MAX_STEPS;
            1: n_steps = 1;
            default: n_steps = $urandom_range(1, MAX_STEPS);
        endcase
        run_len = (phase == 2) ? 120 : $urandom_range(10, 40);
        load_step_count(5'(n_steps));
        tx_gaps = (phase != 2);
        rx_gaps = (phase != 2);
        for (i = 0; i < n_steps; i++) send_beat(random_entry(i));
        send_beat(random_beat(CMD_START));
        repeat (run_len) begin
            pick = $urandom_range(99);
            if (pick < 85) send_beat(random_beat(CMD_TICK));
            else if (pick < 90) send_beat(random_beat(CMD_START));
            else if (pick < 94) send_beat(random_beat(CMD_STOP));
            else send_beat(random_entry($urandom_range(MAX_STEPS - 1)));
        end
    endtask

    task automatic test_random_profiles();
        int target;
        int phase;
        target = beats_sent + RANDOM_BEATS;
        phase = 0;
        while (beats_sent < target) begin
            run_random_phase(phase);
            phase++;
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            tbl_op[i] = OP_HOLD;
            tbl_arg[i] = '0;
            tbl_ticks[i] = '0;
        end
        cur_step = 0;
        ticks_remaining = '0;
        loops_done = '0;
        cur_level = '0;
        seq_active = 1'b0;
        num_steps = 5'd1;
        beats_sent = 0;
        live_beats = 0;
        results_checked = 0;
        mismatch_count = 0;
        table_settings = 0;
        idle_cycles = 0;
        holdoff_request = 0;
        holdoff_left = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_single_hold();
        test_ramp_wrap_and_unknown_op();
        test_repeat_count();
        test_forever_and_zero_duration();
        test_output_holdoff();
        test_random_profiles();

        wait_idle();
        if (profile_outputs_q.size() != 0)
            report_mismatch("results never delivered", 64'(profile_outputs_q.size()), '0);
        $display("run: %0d beats sent, %0d of them acting on the sequencer, %0d results checked",
                 beats_sent, live_beats, results_checked);
        $display("covered %0d step-count settings incl 1 and 16, ramp wrap, repeats, %0d-cycle hold-off",
                 table_settings, HOLDOFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("current_profile_sequencer_core test passed");
        end else begin
            $display("current_profile_sequencer_core test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/cps_pkg.sv
hw/rtl/cps_ram.sv
hw/rtl/current_profile_sequencer_core.sv
bench/tb_current_profile_sequencer_core.sv
